/* hw/rtl/ctd_pkg.sv */
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared widths, constants, types and helper functions for the calendar
// time difference block.
// ----------------------------------------------------------------------------
package ctd_pkg;

    // Field widths
    localparam int unsigned YearW   = 6;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned HourW   = 5;
    localparam int unsigned MinuteW = 6;
    localparam int unsigned ResultW = 16;

    // Day count of one stamp: at most 22645 + 426 + 31
    localparam int unsigned DaysW   = 15;
    // Signed width of the day-count difference
    localparam int unsigned DdW     = DaysW + 1;
    // Signed width that holds a full minute difference
    localparam int unsigned DeltaW  = 27;
    // Signed width of the hour and minute differences
    localparam int unsigned DhW     = HourW + 1;
    localparam int unsigned DmW     = MinuteW + 1;
    // Signed width of the minute-of-day difference (+/- 1923)
    localparam int unsigned RemW    = 12;

    localparam int unsigned MinPerDay  = 1440;
    localparam int unsigned MinPerHour = 60;
    localparam int unsigned HourPerDay = 24;
    localparam int unsigned DaysPerYr  = 365;
    localparam int unsigned SatMax     = 32'h7fff;

    // Days of all months before the given one, common year.
    // Months past December count 30 days each.
    localparam logic [8:0] MonthPrefix [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd395, 9'd425
    };

    // Date part of one stamp
    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
    } t_date;

    // Clamp a non-negative value to the largest positive result
    function automatic logic [ResultW-1:0] sat_result(input logic signed [DeltaW-1:0] v);
        logic [ResultW-1:0] res;
        if (v > $signed(DeltaW'(SatMax))) begin
            res = ResultW'(SatMax);
        end else begin
            res = v[ResultW-1:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/ctd_in_if.sv */
// ----------------------------------------------------------------------------
// ctd_in_if
// Query channel: two calendar stamps and the requested unit.
// ----------------------------------------------------------------------------
interface ctd_in_if;
    logic                         valid;
    logic                         ready;
    logic [ctd_pkg::YearW-1:0]    end_year;
    logic [ctd_pkg::MonthW-1:0]   end_month;
    logic [ctd_pkg::DayW-1:0]     end_day;
    logic [ctd_pkg::HourW-1:0]    end_hour;
    logic [ctd_pkg::MinuteW-1:0]  end_minute;
    logic [ctd_pkg::YearW-1:0]    start_year;
    logic [ctd_pkg::MonthW-1:0]   start_month;
    logic [ctd_pkg::DayW-1:0]     start_day;
    logic [ctd_pkg::HourW-1:0]    start_hour;
    logic [ctd_pkg::MinuteW-1:0]  start_minute;
    logic                         ask_hours;
    logic                         ask_minutes;

    modport source (
        output valid, end_year, end_month, end_day, end_hour, end_minute,
               start_year, start_month, start_day, start_hour, start_minute,
               ask_hours, ask_minutes,
        input  ready
    );
    modport sink (
        input  valid, end_year, end_month, end_day, end_hour, end_minute,
               start_year, start_month, start_day, start_hour, start_minute,
               ask_hours, ask_minutes,
        output ready
    );
endinterface

/* hw/rtl/ctd_out_if.sv */
// ----------------------------------------------------------------------------
// ctd_out_if
// Result channel: time left in the requested unit, or -1.
// ----------------------------------------------------------------------------
interface ctd_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ctd_pkg::ResultW-1:0] time_left;

    modport source (output valid, time_left, input ready);
    modport sink (input valid, time_left, output ready);
endinterface

/* hw/rtl/ctd_stamp_days.sv */
// ----------------------------------------------------------------------------
// ctd_stamp_days
// Day number of one calendar stamp: whole years, months before the
// stamp's month (leap February when year mod 4 is 0) and the day.
// ----------------------------------------------------------------------------
module ctd_stamp_days (
    input  ctd_pkg::t_date                 i_date,
    output logic [ctd_pkg::DaysW-1:0]      o_days
);

    logic [ctd_pkg::YearW-1:0] w_ym1;
    logic [ctd_pkg::DaysW-1:0] w_year_days;
    logic [ctd_pkg::DaysW-1:0] w_month_days;
    logic                      w_leap_add;

    // Days of complete years before this one
    always_comb begin
        w_ym1 = i_date.year - ctd_pkg::YearW'(1);
        if (i_date.year == '0) begin
            w_year_days = '0;
        end else begin
            w_year_days = ctd_pkg::DaysW'(w_ym1) * ctd_pkg::DaysW'(ctd_pkg::DaysPerYr)
                        + ctd_pkg::DaysW'(w_ym1 >> 2);
        end
    end

    // Months before this one, plus the leap day once February is past
    assign w_leap_add   = (i_date.year[1:0] == 2'b00) && (i_date.month >= ctd_pkg::MonthW'(3));
    assign w_month_days = ctd_pkg::DaysW'(ctd_pkg::MonthPrefix[i_date.month])
                        + ctd_pkg::DaysW'(w_leap_add);

    assign o_days = w_year_days + w_month_days + ctd_pkg::DaysW'(i_date.day);

endmodule

/* hw/rtl/calendar_time_difference_top.sv */
// ----------------------------------------------------------------------------
// calendar_time_difference_top
// Time from a start stamp to an end stamp, in hours, minutes or days.
// ----------------------------------------------------------------------------
// Pipeline: input register, day-count register, result register; a query's
//   result is valid once it has passed through all three.
// Throughput: one query per cycle; stalls only when the result register is
//   full and not taken, with backpressure rippling through the three stages.
// Reset: synchronous, active low; clears the stage valid flags only.
// ----------------------------------------------------------------------------
module calendar_time_difference_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctd_in_if.sink      i_in,
    ctd_out_if.source   o_out
);

    // Stage advance: a stage loads when it is empty or its content moves on
    logic w_adv1;
    logic w_adv2;
    logic w_adv3;

    logic r_v1;
    logic r_v2;
    logic r_v3;

    assign w_adv3     = !r_v3 || o_out.ready;
    assign w_adv2     = !r_v2 || w_adv3;
    assign w_adv1     = !r_v1 || w_adv2;
    assign i_in.ready = w_adv1;

    // Stage 1: input register
    ctd_pkg::t_date                  r_end_date;
    ctd_pkg::t_date                  r_start_date;
    logic [ctd_pkg::HourW-1:0]       r1_end_hour;
    logic [ctd_pkg::HourW-1:0]       r1_start_hour;
    logic [ctd_pkg::MinuteW-1:0]     r1_end_min;
    logic [ctd_pkg::MinuteW-1:0]     r1_start_min;
    logic                            r1_ask_hours;
    logic                            r1_ask_minutes;

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_in.valid) begin
            r_end_date     <= '{year: i_in.end_year, month: i_in.end_month,
                                day: i_in.end_day};
            r_start_date   <= '{year: i_in.start_year, month: i_in.start_month,
                                day: i_in.start_day};
            r1_end_hour    <= i_in.end_hour;
            r1_start_hour  <= i_in.start_hour;
            r1_end_min     <= i_in.end_minute;
            r1_start_min   <= i_in.start_minute;
            r1_ask_hours   <= i_in.ask_hours;
            r1_ask_minutes <= i_in.ask_minutes;
        end
    end

    // Day numbers of both stamps
    logic [ctd_pkg::DaysW-1:0] w_end_days;
    logic [ctd_pkg::DaysW-1:0] w_start_days;

    ctd_stamp_days u_end_days (
        .i_date (r_end_date),
        .o_days (w_end_days)
    );

    ctd_stamp_days u_start_days (
        .i_date (r_start_date),
        .o_days (w_start_days)
    );

    // Hour and minute differences
    logic signed [ctd_pkg::DhW-1:0] w_dh;
    logic signed [ctd_pkg::DmW-1:0] w_dm;

    assign w_dh = $signed({1'b0, r1_end_hour}) - $signed({1'b0, r1_start_hour});
    assign w_dm = $signed({1'b0, r1_end_min}) - $signed({1'b0, r1_start_min});

    // Stage 2: day counts and time-of-day differences
    logic [ctd_pkg::DaysW-1:0]       r_end_days;
    logic [ctd_pkg::DaysW-1:0]       r_start_days;
    logic signed [ctd_pkg::DhW-1:0]  r_dh;
    logic signed [ctd_pkg::DmW-1:0]  r_dm;
    logic                            r2_ask_hours;
    logic                            r2_ask_minutes;

    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_v1) begin
            r_end_days     <= w_end_days;
            r_start_days   <= w_start_days;
            r_dh           <= w_dh;
            r_dm           <= w_dm;
            r2_ask_hours   <= r1_ask_hours;
            r2_ask_minutes <= r1_ask_minutes;
        end
    end

    // Difference in minutes and the unit conversions.
    // Division by 60 and 1440 splits into day, hour and minute parts; the
    // floor of the small remainder part is found by compares.
    logic signed [ctd_pkg::DdW-1:0]       w_dd;
    logic signed [ctd_pkg::DeltaW-1:0]    w_dd_x;
    logic signed [ctd_pkg::DeltaW-1:0]    w_dh_x;
    logic signed [ctd_pkg::DeltaW-1:0]    w_dm_x;
    logic signed [ctd_pkg::RemW-1:0]      w_rem;
    logic signed [2:0]                    w_fl_h;
    logic signed [2:0]                    w_fl_d;
    logic signed [ctd_pkg::DeltaW-1:0]    w_delta;
    logic signed [ctd_pkg::DeltaW-1:0]    w_hours;
    logic signed [ctd_pkg::DeltaW-1:0]    w_days;
    logic [ctd_pkg::ResultW-1:0]          w_result;

    always_comb begin
        w_dd   = $signed({1'b0, r_end_days}) - $signed({1'b0, r_start_days});
        w_dd_x = $signed({{(ctd_pkg::DeltaW - ctd_pkg::DdW){w_dd[ctd_pkg::DdW-1]}}, w_dd});
        w_dh_x = $signed({{(ctd_pkg::DeltaW - ctd_pkg::DhW){r_dh[ctd_pkg::DhW-1]}}, r_dh});
        w_dm_x = $signed({{(ctd_pkg::DeltaW - ctd_pkg::DmW){r_dm[ctd_pkg::DmW-1]}}, r_dm});

        w_delta = w_dd_x * $signed(ctd_pkg::DeltaW'(ctd_pkg::MinPerDay))
                + w_dh_x * $signed(ctd_pkg::DeltaW'(ctd_pkg::MinPerHour))
                + w_dm_x;

        // Minute-of-day difference
        w_rem = $signed({{(ctd_pkg::RemW - ctd_pkg::DhW){r_dh[ctd_pkg::DhW-1]}}, r_dh})
              * $signed(ctd_pkg::RemW'(ctd_pkg::MinPerHour))
              + $signed({{(ctd_pkg::RemW - ctd_pkg::DmW){r_dm[ctd_pkg::DmW-1]}}, r_dm});

        // floor(minute difference / 60)
        if (r_dm < -$signed(ctd_pkg::DmW'(ctd_pkg::MinPerHour))) begin
            w_fl_h = -3'sd2;
        end else if (r_dm < 0) begin
            w_fl_h = -3'sd1;
        end else if (r_dm >= $signed(ctd_pkg::DmW'(ctd_pkg::MinPerHour))) begin
            w_fl_h = 3'sd1;
        end else begin
            w_fl_h = 3'sd0;
        end

        // floor(minute-of-day difference / 1440)
        if (w_rem < -$signed(ctd_pkg::RemW'(ctd_pkg::MinPerDay))) begin
            w_fl_d = -3'sd2;
        end else if (w_rem < 0) begin
            w_fl_d = -3'sd1;
        end else if (w_rem >= $signed(ctd_pkg::RemW'(ctd_pkg::MinPerDay))) begin
            w_fl_d = 3'sd1;
        end else begin
            w_fl_d = 3'sd0;
        end

        w_hours = w_dd_x * $signed(ctd_pkg::DeltaW'(ctd_pkg::HourPerDay)) + w_dh_x
                + $signed({{(ctd_pkg::DeltaW - 3){w_fl_h[2]}}, w_fl_h});
        w_days  = w_dd_x + $signed({{(ctd_pkg::DeltaW - 3){w_fl_d[2]}}, w_fl_d});

        // Unit select and saturation; end before start gives -1
        if (w_delta < 0) begin
            w_result = '1;
        end else if (r2_ask_hours) begin
            w_result = ctd_pkg::sat_result(w_hours);
        end else if (r2_ask_minutes) begin
            w_result = ctd_pkg::sat_result(w_delta);
        end else begin
            w_result = ctd_pkg::sat_result(w_days);
        end
    end

    // Stage 3: result register
    logic [ctd_pkg::ResultW-1:0] r_result;

    always_ff @(posedge i_clk) begin
        if (w_adv3 && r_v2) begin
            r_result <= w_result;
        end
    end

    assign o_out.valid     = r_v3;
    assign o_out.time_left = $signed(r_result);

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_in.valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

endmodule
